>>> sv/double_hash_open_address_table_core_macros.svh
// Assertion macros for the hash table core
`ifndef DOUBLE_HASH_OPEN_ADDRESS_TABLE_CORE_MACROS_SVH
`define DOUBLE_HASH_OPEN_ADDRESS_TABLE_CORE_MACROS_SVH

// Implication check, disabled while in reset
`define DH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, disabled while in reset
`define DH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dhoat_pkg.sv
`timescale 1ns / 1ps
package dhoat_pkg;
  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int SIZE_W = 11;
  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam int WALK_W = SIZE_W + 1;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd16;
  localparam logic [SIZE_W-1:0] SIZE_MIN = 11'd3;
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SLOTS);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_ADDR,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;
endpackage

>>> sv/dhoat_req_if.sv
`timescale 1ns / 1ps
interface dhoat_req_if;
  logic             valid;
  logic             ready;
  dhoat_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/dhoat_rsp_if.sv
`timescale 1ns / 1ps
interface dhoat_rsp_if;
  logic             valid;
  logic             ready;
  dhoat_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/double_hash_open_address_table_core.sv
`timescale 1ns / 1ps
// Double-hashed open-addressing key/value table, up to 1024 slots. One item
// (insert, lookup or delete) is processed at a time. After reset the slot
// flag memory is cleared in one pass over all 1024 slots, during which no
// item is taken. An item first computes key mod S and key mod (S-2) with a
// restoring shift/subtract divider (both remainders in parallel, one key bit
// per cycle), then forms the start slot and step, then walks the probe
// sequence through the slot memories, each probe a synchronous read followed
// by a compare/write back, up to S+1 probes, and finally presents the result
// from a done state. The unused mode skips the probe walk and returns a miss.
// The next item can be taken from the cycle after the result is accepted.
// Slot key/value storage is undefined until written.
// The table size from cfg_wdata is clamped to 3..1024 and sampled when an
// item is accepted.
`include "double_hash_open_address_table_core_macros.svh"
module double_hash_open_address_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  dhoat_req_if.sink                     in_req,
  dhoat_rsp_if.source                   out_rsp,
  input  logic                          cfg_we,
  input  logic [dhoat_pkg::SIZE_W-1:0]  cfg_wdata
);
  localparam int SW = dhoat_pkg::SLOT_W;
  localparam int ZW = dhoat_pkg::SIZE_W;
  localparam int KW = dhoat_pkg::KEY_W;
  localparam int VW = dhoat_pkg::VAL_W;
  localparam int CW = dhoat_pkg::CNT_W;
  localparam int WW = dhoat_pkg::WALK_W;
  localparam int DIV_W = $clog2(KW + 1);

  // slot memories: key/value data and {used, removed} flags
  logic [KW+VW-1:0] data_mem [dhoat_pkg::MAX_SLOTS];
  logic [1:0]       flag_mem [dhoat_pkg::MAX_SLOTS];

  dhoat_pkg::state_t state_r, state_nxt;
  logic [ZW-1:0] size_cfg_r;
  logic [ZW-1:0] size_r, size_nxt;
  dhoat_pkg::req_t req_r;
  logic [ZW-1:0] rem_a_r, rem_a_nxt;   // key mod S
  logic [ZW-1:0] rem_b_r, rem_b_nxt;   // key mod (S-2)
  logic [DIV_W-1:0] bit_r, bit_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic [ZW-1:0] step_r, step_nxt;
  logic [WW-1:0] walk_r, walk_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [KW-1:0] rd_key_r;
  logic rd_used_r, rd_rem_r;
  dhoat_pkg::rsp_t rsp_r, rsp_nxt;
  logic rsp_valid_r, rsp_valid_nxt;
  logic wr_en, rm_en;
  logic          flag_we;
  logic [SW-1:0] flag_addr;
  logic [1:0]    flag_wdata;

  // clamped size from the register
  logic [ZW-1:0] size_eff;
  always_comb begin
    priority if (size_cfg_r < dhoat_pkg::SIZE_MIN) size_eff = dhoat_pkg::SIZE_MIN;
    else if (size_cfg_r > dhoat_pkg::SIZE_MAX) size_eff = dhoat_pkg::SIZE_MAX;
    else size_eff = size_cfg_r;
  end

  // divider trial subtractions
  logic [ZW:0] ta, tb, da, db;
  logic [ZW-1:0] size_m2;
  logic          kbit;
  assign size_m2 = size_r - ZW'(2);
  assign kbit = req_r.key[bit_r[DIV_W-1:0]];
  assign ta = {rem_a_r, kbit};
  assign tb = {rem_b_r, kbit};
  assign da = ta - {1'b0, size_r};
  assign db = tb - {1'b0, size_m2};

  // next probe index: (idx + step) mod S, both below S
  logic [ZW:0] idx_sum, idx_wrap;
  assign idx_sum = {1'b0, ZW'(idx_r)} + {1'b0, step_r};
  assign idx_wrap = idx_sum - {1'b0, size_r};

  logic is_ins, hit, last_probe;
  assign is_ins = (req_r.mode == dhoat_pkg::MODE_INSERT);
  assign hit = is_ins ? !rd_used_r
                      : (rd_used_r && !rd_rem_r && (rd_key_r == req_r.key));
  assign last_probe = (walk_r == {1'b0, size_r});

  assign in_req.ready = (state_r == dhoat_pkg::S_IDLE) && !rsp_valid_r;
  assign out_rsp.valid = rsp_valid_r;
  assign out_rsp.payload = rsp_r;

  always_comb begin
    state_nxt = state_r;
    size_nxt = size_r;
    rem_a_nxt = rem_a_r;
    rem_b_nxt = rem_b_r;
    bit_nxt = bit_r;
    idx_nxt = idx_r;
    clr_nxt = clr_r;
    step_nxt = step_r;
    walk_nxt = walk_r;
    count_nxt = count_r;
    rsp_nxt = rsp_r;
    rsp_valid_nxt = rsp_valid_r;
    wr_en = 1'b0;
    rm_en = 1'b0;
    if (rsp_valid_r && out_rsp.ready) rsp_valid_nxt = 1'b0;
    unique case (state_r)
      // clear the slot flags one entry per cycle
      dhoat_pkg::S_CLEAR: begin
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(dhoat_pkg::MAX_SLOTS - 1)) state_nxt = dhoat_pkg::S_IDLE;
      end
      dhoat_pkg::S_IDLE: begin
        if (in_req.valid && in_req.ready) begin
          size_nxt = size_eff;
          rem_a_nxt = '0;
          rem_b_nxt = '0;
          bit_nxt = DIV_W'(KW - 1);
          state_nxt = dhoat_pkg::S_MOD;
        end
      end
      // one remainder bit per cycle, MSB first
      dhoat_pkg::S_MOD: begin
        rem_a_nxt = da[ZW] ? ta[ZW-1:0] : da[ZW-1:0];
        rem_b_nxt = db[ZW] ? tb[ZW-1:0] : db[ZW-1:0];
        bit_nxt = bit_r - DIV_W'(1);
        if (bit_r == '0) state_nxt = dhoat_pkg::S_ADDR;
      end
      dhoat_pkg::S_ADDR: begin
        idx_nxt = rem_a_r[SW-1:0];
        step_nxt = rem_b_r + ZW'(1);
        walk_nxt = '0;
        if (req_r.mode == dhoat_pkg::MODE_NONE) begin
          rsp_nxt = '{status: dhoat_pkg::ST_MISS, found: 1'b0, slot_index: '0,
                      entry_count: count_r};
          rsp_valid_nxt = 1'b1;
          state_nxt = dhoat_pkg::S_IDLE;
        end else begin
          state_nxt = dhoat_pkg::S_READ;
        end
      end
      dhoat_pkg::S_READ: state_nxt = dhoat_pkg::S_CHECK;
      dhoat_pkg::S_CHECK: begin
        if (hit) begin
          if (is_ins) begin
            wr_en = 1'b1;
            if (count_r != dhoat_pkg::COUNT_MAX) count_nxt = count_r + CW'(1);
          end else if (req_r.mode == dhoat_pkg::MODE_DELETE) begin
            rm_en = 1'b1;
          end
          rsp_nxt.status = dhoat_pkg::ST_OK;
          rsp_nxt.found = !is_ins;
          rsp_nxt.slot_index = idx_r;
          rsp_nxt.entry_count = is_ins && (count_r != dhoat_pkg::COUNT_MAX)
                                ? count_r + CW'(1) : count_r;
          state_nxt = dhoat_pkg::S_DONE;
        end else if (last_probe) begin
          rsp_nxt.status = is_ins ? dhoat_pkg::ST_FULL : dhoat_pkg::ST_MISS;
          rsp_nxt.found = 1'b0;
          rsp_nxt.slot_index = '0;
          rsp_nxt.entry_count = count_r;
          state_nxt = dhoat_pkg::S_DONE;
        end else begin
          idx_nxt = idx_wrap[ZW] ? idx_sum[SW-1:0] : idx_wrap[SW-1:0];
          walk_nxt = walk_r + WW'(1);
          state_nxt = dhoat_pkg::S_READ;
        end
      end
      dhoat_pkg::S_DONE: begin
        rsp_valid_nxt = 1'b1;
        state_nxt = dhoat_pkg::S_IDLE;
      end
      default: state_nxt = dhoat_pkg::S_IDLE;
    endcase
  end

  // flag write port: clearing pass, else insert or delete
  always_comb begin
    if (state_r == dhoat_pkg::S_CLEAR) begin
      flag_we = 1'b1;
      flag_addr = clr_r;
      flag_wdata = 2'b00;
    end else begin
      flag_we = wr_en || rm_en;
      flag_addr = idx_r;
      flag_wdata = {1'b1, rm_en};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dhoat_pkg::S_CLEAR;
      clr_r <= '0;
      size_cfg_r <= dhoat_pkg::SIZE_RESET;
      count_r <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      count_r <= count_nxt;
      rsp_valid_r <= rsp_valid_nxt;
      if (cfg_we) size_cfg_r <= cfg_wdata;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) req_r <= in_req.payload;
    size_r <= size_nxt;
    rem_a_r <= rem_a_nxt;
    rem_b_r <= rem_b_nxt;
    bit_r <= bit_nxt;
    idx_r <= idx_nxt;
    step_r <= step_nxt;
    walk_r <= walk_nxt;
    rsp_r <= rsp_nxt;
  end

  // slot data memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) data_mem[idx_r] <= {req_r.key, req_r.value};
    rd_key_r <= data_mem[idx_r][KW+VW-1:VW];
  end

  // slot flag memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_addr] <= flag_wdata;
    {rd_used_r, rd_rem_r} <= flag_mem[idx_r];
  end

  `DH_ASSERT_IMP(a_no_accept_busy, clk, rst_n,
    (state_r != dhoat_pkg::S_IDLE), !in_req.ready, "item accepted while busy")
  `DH_ASSERT_IMP(a_idx_range, clk, rst_n,
    (state_r == dhoat_pkg::S_CHECK), ({1'b0, ZW'(idx_r)} < {1'b0, size_r}),
    "probe index beyond table size")
  `DH_ASSERT_IMP(a_miss_slot_zero, clk, rst_n,
    (out_rsp.valid && (out_rsp.payload.status != dhoat_pkg::ST_OK)),
    (out_rsp.payload.slot_index == '0), "slot index nonzero on failure")
  `DH_ASSERT_NXT(a_count_mono, clk, rst_n, 1'b1,
    (count_r >= $past(count_r)), "entry count decreased")
endmodule

>>> tb/tb_double_hash_open_address_table_core.sv
`timescale 1ns / 1ps
module tb_double_hash_open_address_table_core;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int KW = dhoat_pkg::KEY_W;
  localparam int VW = dhoat_pkg::VAL_W;
  localparam int ZW = dhoat_pkg::SIZE_W;
  localparam int SW = dhoat_pkg::SLOT_W;
  localparam int CW = dhoat_pkg::CNT_W;
  localparam int NSLOT = dhoat_pkg::MAX_SLOTS;

  // Shadow copy of the slot table; predicts one result item per request item
  class table_scoreboard;
    bit [KW-1:0]       keys [NSLOT];
    bit [VW-1:0]       vals [NSLOT];
    bit                used [NSLOT];
    bit                removed [NSLOT];
    bit [CW-1:0]       total;
    bit [ZW-1:0]       size_reg;
    dhoat_pkg::rsp_t   pending_rsp [$];
    int                mismatches;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        used[i] = 0;
        removed[i] = 0;
      end
      total = '0;
      size_reg = dhoat_pkg::SIZE_RESET;
      mismatches = 0;
    endfunction

    function int unsigned live_size();
      int unsigned s;
      s = size_reg;
      if (s < 3) s = 3;
      if (s > NSLOT) s = NSLOT;
      return s;
    endfunction

    // Walk the double-hash probe sequence, S+1 probes at most
    function bit walk(bit [KW-1:0] key, bit want_free, output int unsigned where);
      int unsigned s, step, idx;
      s = live_size();
      step = 1 + key % (s - 2);
      idx = key % s;
      where = 0;
      for (int unsigned i = 0; i <= s; i++) begin
        if (want_free) begin
          if (!used[idx]) begin
            where = idx;
            return 1;
          end
        end else if (used[idx] && !removed[idx] && keys[idx] == key) begin
          where = idx;
          return 1;
        end
        idx = (idx + step) % s;
      end
      return 0;
    endfunction

    function void note_request(dhoat_pkg::req_t r);
      dhoat_pkg::rsp_t e;
      int unsigned where;
      e.status = dhoat_pkg::ST_MISS;
      e.found = 0;
      e.slot_index = '0;
      if (r.mode == dhoat_pkg::MODE_INSERT) begin
        if (walk(r.key, 1, where)) begin
          keys[where] = r.key;
          vals[where] = r.value;
          used[where] = 1;
          removed[where] = 0;
          if (total != dhoat_pkg::COUNT_MAX) total++;
          e.status = dhoat_pkg::ST_OK;
          e.slot_index = where[SW-1:0];
        end else begin
          e.status = dhoat_pkg::ST_FULL;
        end
      end else if (r.mode == dhoat_pkg::MODE_LOOKUP || r.mode == dhoat_pkg::MODE_DELETE) begin
        if (walk(r.key, 0, where)) begin
          if (r.mode == dhoat_pkg::MODE_DELETE) removed[where] = 1;
          e.status = dhoat_pkg::ST_OK;
          e.found = 1;
          e.slot_index = where[SW-1:0];
        end
      end
      e.entry_count = total;
      pending_rsp.push_back(e);
    endfunction

    function void check_response(dhoat_pkg::rsp_t got);
      dhoat_pkg::rsp_t e;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item %p", got);
        return;
      end
      e = pending_rsp.pop_front();
      if (got.status !== e.status || got.found !== e.found ||
          got.slot_index !== e.slot_index || got.entry_count !== e.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p got %p", e, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ZW-1:0] cfg_wdata;

  dhoat_req_if req_ch ();
  dhoat_rsp_if rsp_ch ();

  double_hash_open_address_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch.sink),
    .out_rsp   (rsp_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  table_scoreboard sb = new();

  int gap_pct;
  int stall_pct;
  int hold_cycles;
  int hold_req;
  int hold_seen;
  int quiet_cycles;
  bit [KW-1:0] key_pool [$];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.payload);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 400;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("double_hash_open_address_table_core verification failed");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] mode, logic [KW-1:0] key, logic [VW-1:0] value);
    dhoat_pkg::req_t r;
    r.mode = mode;
    r.key = key;
    r.value = value;
    while ($urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
    if (mode == dhoat_pkg::MODE_INSERT) key_pool.push_back(key);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [ZW-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.size_reg = v;
  endtask

  function automatic logic [KW-1:0] pick_key();
    int c;
    c = $urandom_range(0, 99);
    if (c < 70 && key_pool.size() != 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (c < 85) return KW'($urandom_range(0, 4000));
    return KW'($urandom());
  endfunction

  // Random mix of inserts, lookups, deletes and the unused mode, mostly on known keys
  task automatic random_items(int n);
    int c;
    logic [1:0] m;
    logic [KW-1:0] k;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      if (c < 40) m = dhoat_pkg::MODE_INSERT;
      else if (c < 70) m = dhoat_pkg::MODE_LOOKUP;
      else if (c < 95) m = dhoat_pkg::MODE_DELETE;
      else m = dhoat_pkg::MODE_NONE;
      if (m == dhoat_pkg::MODE_INSERT && $urandom_range(0, 1) == 1) k = KW'($urandom());
      else k = pick_key();
      send_item(m, k, $urandom());
    end
  endtask

  int sizes [15] = '{3, 0, 2, 5, 7, 11, 31, 64, 100, 257, 1024, 2047, 1500, 13, 4};
  int counts [15] = '{100, 60, 60, 120, 120, 150, 200, 200, 150, 120, 40, 30, 20, 150, 100};

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.payload <= '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, collisions, duplicates, tombstones, unused mode
    send_item(dhoat_pkg::MODE_INSERT, 31'd0, 32'h8000_0000);
    send_item(dhoat_pkg::MODE_INSERT, 31'h7fff_ffff, 32'h7fff_ffff);
    send_item(dhoat_pkg::MODE_INSERT, 31'd16, 32'hffff_ffff);
    send_item(dhoat_pkg::MODE_INSERT, 31'd0, 32'd0);
    send_item(dhoat_pkg::MODE_LOOKUP, 31'd0, '0);
    send_item(dhoat_pkg::MODE_DELETE, 31'd0, '0);
    send_item(dhoat_pkg::MODE_LOOKUP, 31'd0, '0);
    send_item(dhoat_pkg::MODE_DELETE, 31'd0, '0);
    send_item(dhoat_pkg::MODE_DELETE, 31'd0, '0);
    send_item(dhoat_pkg::MODE_LOOKUP, 31'd0, '0);
    send_item(dhoat_pkg::MODE_LOOKUP, 31'h7fff_ffff, '0);
    send_item(dhoat_pkg::MODE_LOOKUP, 31'd12345, '0);
    send_item(dhoat_pkg::MODE_NONE, 31'h7fff_ffff, 32'hffff_ffff);
    send_item(dhoat_pkg::MODE_INSERT, 31'd32, 32'h1234_5678);
    // Smallest table: fill it, then a full probe walk
    write_size(11'd3);
    for (int i = 0; i < 5; i++) send_item(dhoat_pkg::MODE_INSERT, 31'(i * 7), $urandom());
    send_item(dhoat_pkg::MODE_LOOKUP, 31'd7, '0);
    send_item(dhoat_pkg::MODE_DELETE, 31'd7, '0);
    send_item(dhoat_pkg::MODE_INSERT, 31'd7, '0);

    // Random phases over a range of sizes and idling mixes
    for (int p = 0; p < 15; p++) begin
      write_size(ZW'(sizes[p]));
      case (p % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 84; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 84; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      random_items(counts[p] / 2);
      if (p == 3) begin
        // Long receiver hold-off while the sender keeps offering items
        hold_req = hold_req + 1;
        gap_pct = 0;
      end
      if (p == 5) drain();
      random_items(counts[p] - counts[p] / 2);
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
      $display("double_hash_open_address_table_core verification clean");
    else
      $display("double_hash_open_address_table_core verification failed");
    $finish;
  end
endmodule
